// ----- hw/rtl/rpa_pkg.sv -----
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types and constants for the register pool allocator: request codes,
// owner cell commands and status, and controller states.
// ----------------------------------------------------------------------------
package rpa_pkg;

   localparam int NUM_REGS_DEF = 16;
   localparam int ID_WIDTH_DEF = 16;
   localparam int REG_W_DEF    = $clog2(NUM_REGS_DEF);

   localparam int OPCODE_W = 3;
   localparam int VALUE_W  = 16;
   localparam int REGNO_W  = 4;
   localparam int MASK_W   = 16;

   localparam int REQ_W = 24;
   localparam int RSP_W = 56;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ALLOC_ANY   = 3'd0,
      OP_ALLOC_NAMED = 3'd1,
      OP_RESERVE     = 3'd2,
      OP_FREE_REG    = 3'd3,
      OP_FREE_VALUE  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_MATCH,
      CELL_KILL,
      CELL_PACK,
      CELL_APPEND
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        kill_r;
      logic        kill_v;
   } cell_ctl_type;

   typedef struct packed {
      logic valid;
      logic gap;
      logic rhit;
      logic vhit;
   } cell_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_MATCH,
      ST_APPLY,
      ST_PACK,
      ST_APPEND,
      ST_FINISH
   } fsm_state_type;

endpackage

// ----- hw/rtl/rpa_cell.sv -----
// ----------------------------------------------------------------------------
// rpa_cell
// One entry of the owner list: a (value, register) pair with a valid bit.
// Compares against the lookup keys, drops itself on a kill, pulls its upper
// neighbor into a hole, and takes the new entry at the end of the list.
// ----------------------------------------------------------------------------
module rpa_cell #(
   parameter int ID_WIDTH = rpa_pkg::ID_WIDTH_DEF,
   parameter int REG_W    = rpa_pkg::REG_W_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rpa_pkg::cell_ctl_type ctl,
   input  logic [ID_WIDTH-1:0]   key_value,
   input  logic [REG_W-1:0]      key_reg,
   input  logic                  down_valid,
   input  logic                  up_valid,
   input  logic [ID_WIDTH-1:0]   up_value,
   input  logic [REG_W-1:0]      up_reg,
   output logic [ID_WIDTH-1:0]   cell_value,
   output logic [REG_W-1:0]      cell_reg,
   output rpa_pkg::cell_stat_type stat
);
   import rpa_pkg::*;

   logic                valid_ff, valid_in;
   logic                rhit_ff, rhit_in;
   logic                vhit_ff, vhit_in;
   logic [ID_WIDTH-1:0] value_ff, value_in;
   logic [REG_W-1:0]    reg_ff, reg_in;

   always_comb begin
      valid_in = valid_ff;
      rhit_in  = rhit_ff;
      vhit_in  = vhit_ff;
      value_in = value_ff;
      reg_in   = reg_ff;
      unique case (ctl.op)
         CELL_HOLD: begin
         end
         CELL_MATCH: begin
            rhit_in = valid_ff && (reg_ff == key_reg);
            vhit_in = valid_ff && (value_ff == key_value);
         end
         CELL_KILL: begin
            if ((rhit_ff && ctl.kill_r) || (vhit_ff && ctl.kill_v)) begin
               valid_in = 1'b0;
            end
         end
         CELL_PACK: begin
            if (!valid_ff && up_valid) begin
               valid_in = 1'b1;
               value_in = up_value;
               reg_in   = up_reg;
            end else if (valid_ff && !down_valid) begin
               valid_in = 1'b0;
            end
         end
         CELL_APPEND: begin
            if (!valid_ff && down_valid) begin
               valid_in = 1'b1;
               value_in = key_value;
               reg_in   = key_reg;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rhit_ff  <= 1'b0;
         vhit_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         rhit_ff  <= rhit_in;
         vhit_ff  <= vhit_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      reg_ff   <= reg_in;
   end

   assign cell_value = value_ff;
   assign cell_reg   = reg_ff;
   assign stat.valid = valid_ff;
   assign stat.gap   = !valid_ff && up_valid;
   assign stat.rhit  = rhit_ff;
   assign stat.vhit  = vhit_ff;

endmodule

// ----- hw/rtl/rpa_find_free.sv -----
// ----------------------------------------------------------------------------
// rpa_find_free
// Priority encoder over the occupied mask: lowest free register.
// ----------------------------------------------------------------------------
module rpa_find_free #(
   parameter int NUM_REGS = rpa_pkg::NUM_REGS_DEF,
   parameter int REG_W    = rpa_pkg::REG_W_DEF
) (
   input  logic [NUM_REGS-1:0] occ,
   output logic                found,
   output logic [REG_W-1:0]    idx
);
   import rpa_pkg::*;

   always_comb begin
      idx = '0;
      for (int i = NUM_REGS - 1; i >= 0; i--) begin
         if (!occ[i]) begin
            idx = REG_W'(i);
         end
      end
      found = ~&occ;
   end

endmodule

// ----- hw/rtl/register_pool_allocator_fifo_spill.sv -----
// ----------------------------------------------------------------------------
// register_pool_allocator_fifo_spill
// Register pool allocator with lowest-free choice and oldest-owner eviction.
//
// Takes one request at a time and returns one response per request. A
// request passes through LOOKUP, MATCH, APPLY and PACK, then APPEND when a
// new owner entry is appended, then FINISH, which loads the response once
// the output register is free. PACK repeats while removed owner entries
// leave holes in the row of owner cells, which closes holes one position per
// cycle. A new request is accepted while the previous response still waits
// on rsp_tready.
// ----------------------------------------------------------------------------
module register_pool_allocator_fifo_spill #(
   parameter int NUM_REGS = rpa_pkg::NUM_REGS_DEF,
   parameter int ID_WIDTH = rpa_pkg::ID_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // opcode[2:0], has_value[3], value_id[19:4], reg_no[23:20]
   input  logic [rpa_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // granted[0], granted_reg[4:1], spilled[5], spilled_value_id[21:6],
   // error[22], occupied_mask[38:23], used_mask[54:39], zero[55]
   output logic [rpa_pkg::RSP_W-1:0] rsp_tdata
);
   import rpa_pkg::*;

   localparam int REG_W = $clog2(NUM_REGS);

   fsm_state_type state_ff, state_in;

   op_type                op_ff, op_in;
   logic                  hv_ff, hv_in;
   logic [ID_WIDTH-1:0]   vid_ff, vid_in;
   logic [REGNO_W-1:0]    rno_ff, rno_in;
   logic                  in_pool_ff, in_pool_in;
   logic [REG_W-1:0]      target_ff, target_in;
   logic                  free_ff, free_in;
   logic                  empty_ff, empty_in;
   logic                  app_ff, app_in;
   logic [NUM_REGS-1:0]   occ_ff, occ_in;
   logic [NUM_REGS-1:0]   used_ff, used_in;
   logic                  res_granted_ff, res_granted_in;
   logic [REG_W-1:0]      res_greg_ff, res_greg_in;
   logic                  res_sp_ff, res_sp_in;
   logic [ID_WIDTH-1:0]   res_spid_ff, res_spid_in;
   logic                  res_err_ff, res_err_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0]      rsp_tdata_ff, rsp_tdata_in;

   logic                  req_accept;
   logic                  rsp_load;
   logic                  pick_found;
   logic [REG_W-1:0]      pick_idx;
   cell_ctl_type          cell_ctl;
   logic                  kill_r_c, kill_v_c;

   logic [ID_WIDTH-1:0]   cell_value [NUM_REGS];
   logic [REG_W-1:0]      cell_reg   [NUM_REGS];
   cell_stat_type         cell_stat  [NUM_REGS];

   logic                  any_r, any_v, gap_any;
   logic [ID_WIDTH-1:0]   r_val;
   logic [REG_W-1:0]      v_reg;
   logic [NUM_REGS-1:0]   rhit_vec, vhit_vec, own_mask;
   logic [NUM_REGS-1:0]   tbit, vbit;

   logic [5:0]            greg_w;
   logic [31:0]           spid_w;
   logic [63:0]           occ_w, used_w;

   // request fields
   assign req_accept = req_tvalid && req_tready;
   assign op_in      = req_accept ? op_type'(req_tdata[2:0]) : op_ff;
   assign hv_in      = req_accept ? req_tdata[3] : hv_ff;
   assign vid_in     = req_accept ? ID_WIDTH'(req_tdata[19:4]) : vid_ff;
   assign rno_in     = req_accept ? req_tdata[23:20] : rno_ff;
   assign in_pool_in = req_accept ? (32'(req_tdata[23:20]) < NUM_REGS) : in_pool_ff;

   rpa_find_free #(
      .NUM_REGS (NUM_REGS),
      .REG_W    (REG_W)
   ) u_find_free (
      .occ   (occ_ff),
      .found (pick_found),
      .idx   (pick_idx)
   );

   // resolve the register the request targets
   always_comb begin
      target_in = target_ff;
      free_in   = free_ff;
      empty_in  = empty_ff;
      if (state_ff == ST_LOOKUP) begin
         free_in  = pick_found;
         empty_in = !cell_stat[0].valid;
         if (op_ff == OP_ALLOC_ANY) begin
            target_in = pick_found ? pick_idx : cell_reg[0];
         end else begin
            target_in = REG_W'(rno_ff);
         end
      end
   end

   // owner cell row
   for (genvar g = 0; g < NUM_REGS; g++) begin : g_cell
      logic                down_v, up_v;
      logic [ID_WIDTH-1:0] up_value;
      logic [REG_W-1:0]    up_reg;
      if (g == 0) begin : g_bottom
         assign down_v = 1'b1;
      end else begin : g_mid
         assign down_v = cell_stat[g-1].valid;
      end
      if (g == NUM_REGS - 1) begin : g_top
         assign up_v     = 1'b0;
         assign up_value = '0;
         assign up_reg   = '0;
      end else begin : g_below
         assign up_v     = cell_stat[g+1].valid;
         assign up_value = cell_value[g+1];
         assign up_reg   = cell_reg[g+1];
      end
      rpa_cell #(
         .ID_WIDTH (ID_WIDTH),
         .REG_W    (REG_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .key_value  (vid_ff),
         .key_reg    (target_ff),
         .down_valid (down_v),
         .up_valid   (up_v),
         .up_value   (up_value),
         .up_reg     (up_reg),
         .cell_value (cell_value[g]),
         .cell_reg   (cell_reg[g]),
         .stat       (cell_stat[g])
      );
   end

   // gather hits from the row
   always_comb begin
      any_r    = 1'b0;
      any_v    = 1'b0;
      gap_any  = 1'b0;
      r_val    = '0;
      v_reg    = '0;
      own_mask = '0;
      for (int i = 0; i < NUM_REGS; i++) begin
         rhit_vec[i] = cell_stat[i].rhit;
         vhit_vec[i] = cell_stat[i].vhit;
         gap_any     = gap_any | cell_stat[i].gap;
         if (cell_stat[i].rhit) begin
            any_r = 1'b1;
            r_val = r_val | cell_value[i];
         end
         if (cell_stat[i].vhit) begin
            any_v = 1'b1;
            v_reg = v_reg | cell_reg[i];
         end
         if (cell_stat[i].valid) begin
            own_mask = own_mask | (NUM_REGS'(1) << cell_reg[i]);
         end
      end
   end

   assign tbit = NUM_REGS'(1) << target_ff;
   assign vbit = NUM_REGS'(1) << v_reg;

   // apply the request to masks and decide list edits
   always_comb begin
      occ_in         = occ_ff;
      used_in        = used_ff;
      app_in         = app_ff;
      kill_r_c       = 1'b0;
      kill_v_c       = 1'b0;
      res_granted_in = res_granted_ff;
      res_greg_in    = res_greg_ff;
      res_sp_in      = res_sp_ff;
      res_spid_in    = res_spid_ff;
      res_err_in     = res_err_ff;
      if (state_ff == ST_APPLY) begin
         app_in         = 1'b0;
         res_granted_in = 1'b0;
         res_sp_in      = 1'b0;
         res_spid_in    = '0;
         res_err_in     = 1'b0;
         unique case (op_ff)
            OP_ALLOC_ANY: begin
               if (free_ff || !empty_ff) begin
                  if (!free_ff) begin
                     kill_r_c    = 1'b1;
                     res_sp_in   = any_r;
                     res_spid_in = r_val;
                  end
                  kill_v_c       = hv_ff;
                  app_in         = hv_ff;
                  occ_in         = occ_ff | tbit;
                  used_in        = used_ff | tbit;
                  res_granted_in = 1'b1;
               end else begin
                  res_err_in = 1'b1;
               end
            end
            OP_ALLOC_NAMED: begin
               if (in_pool_ff) begin
                  if (hv_ff && any_v && (v_reg == target_ff)) begin
                     res_granted_in = 1'b1;
                  end else if ((occ_ff & tbit) != '0 && !any_r) begin
                     res_err_in = 1'b1;
                     occ_in     = occ_ff & ~tbit;
                  end else begin
                     if ((occ_ff & tbit) != '0) begin
                        kill_r_c    = 1'b1;
                        res_sp_in   = 1'b1;
                        res_spid_in = r_val;
                     end
                     kill_v_c       = hv_ff;
                     app_in         = hv_ff;
                     occ_in         = occ_ff | tbit;
                     used_in        = used_ff | tbit;
                     res_granted_in = 1'b1;
                  end
               end
            end
            OP_RESERVE: begin
               if (in_pool_ff) begin
                  if (((occ_ff & tbit) != '0) && any_r) begin
                     kill_r_c    = 1'b1;
                     res_sp_in   = 1'b1;
                     res_spid_in = r_val;
                  end
                  occ_in         = occ_ff | tbit;
                  used_in        = used_ff | tbit;
                  res_granted_in = 1'b1;
               end
            end
            OP_FREE_REG: begin
               if (in_pool_ff) begin
                  occ_in = occ_ff & ~tbit;
                  if (any_r) begin
                     kill_r_c    = 1'b1;
                     res_sp_in   = 1'b1;
                     res_spid_in = r_val;
                  end
               end
            end
            OP_FREE_VALUE: begin
               if (any_v) begin
                  occ_in      = occ_ff & ~vbit;
                  kill_v_c    = 1'b1;
                  res_sp_in   = 1'b1;
                  res_spid_in = vid_ff;
               end
            end
            default: begin
            end
         endcase
         res_greg_in = res_granted_in ? target_ff : '0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_accept) state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_MATCH;
         ST_MATCH:  state_in = ST_APPLY;
         ST_APPLY:  state_in = ST_PACK;
         ST_PACK: begin
            if (!gap_any) begin
               state_in = app_ff ? ST_APPEND : ST_FINISH;
            end
         end
         ST_APPEND: state_in = ST_FINISH;
         ST_FINISH: if (rsp_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_tvalid_ff || rsp_tready);

   // controller outputs
   always_comb begin
      req_tready      = (state_ff == ST_IDLE);
      cell_ctl.kill_r = kill_r_c;
      cell_ctl.kill_v = kill_v_c;
      unique case (state_ff)
         ST_MATCH:  cell_ctl.op = CELL_MATCH;
         ST_APPLY:  cell_ctl.op = CELL_KILL;
         ST_PACK:   cell_ctl.op = CELL_PACK;
         ST_APPEND: cell_ctl.op = CELL_APPEND;
         default:   cell_ctl.op = CELL_HOLD;
      endcase
   end

   // response register
   assign greg_w = 6'(res_greg_ff);
   assign spid_w = 32'(res_spid_ff);
   assign occ_w  = 64'(occ_ff);
   assign used_w = 64'(used_ff);

   always_comb begin
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {1'b0, used_w[MASK_W-1:0], occ_w[MASK_W-1:0], res_err_ff,
                          spid_w[VALUE_W-1:0], res_sp_ff, greg_w[REGNO_W-1:0],
                          res_granted_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         occ_ff        <= '0;
         used_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         used_ff       <= used_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      hv_ff          <= hv_in;
      vid_ff         <= vid_in;
      rno_ff         <= rno_in;
      in_pool_ff     <= in_pool_in;
      target_ff      <= target_in;
      free_ff        <= free_in;
      empty_ff       <= empty_in;
      app_ff         <= app_in;
      res_granted_ff <= res_granted_in;
      res_greg_ff    <= res_greg_in;
      res_sp_ff      <= res_sp_in;
      res_spid_ff    <= res_spid_in;
      res_err_ff     <= res_err_in;
      rsp_tdata_ff   <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_occ_in_used: assert property (@(posedge clock) disable iff (reset)
      (occ_ff & ~used_ff) == '0)
      else $error("occupied register missing from used mask");

   a_list_packed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !gap_any)
      else $error("owner list has a hole while idle");

   a_owner_occupied: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ((own_mask & ~occ_ff) == '0))
      else $error("owner entry names a free register");

   a_rhit_single: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |-> $onehot0(rhit_vec))
      else $error("register matches more than one owner entry");

   a_vhit_single: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |-> $onehot0(vhit_vec))
      else $error("value matches more than one owner entry");

endmodule

// ----- sim/register_pool_allocator_fifo_spill_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_pool_allocator_fifo_spill_tb
// Self-checking bench for the register pool allocator. Directed requests
// cover the first-free pick, named grants, already-held grants, reserve, both
// free paths and eviction with and without owners. Random requests follow
// under several idle and stall mixes and one long output hold-off. Every
// response is checked field by field against an in-bench pool model.
// ----------------------------------------------------------------------------
module register_pool_allocator_fifo_spill_tb;
   import rpa_pkg::*;

   localparam int POOL_SIZE    = NUM_REGS_DEF;
   localparam int DRAIN_CYCLES = POOL_SIZE + 14;
   localparam int STALL_LIMIT  = 2000;
   localparam int LONG_HOLD    = 300;
   localparam int RANDOM_ITEMS = 280;

   typedef struct packed {
      logic [3:0]  reg_no;
      logic [15:0] value_id;
      logic        has_value;
      op_type      opcode;
   } pool_req_type;

   typedef struct packed {
      logic        zero_pad;
      logic [15:0] used_mask;
      logic [15:0] occupied_mask;
      logic        error;
      logic [15:0] spilled_value_id;
      logic        spilled;
      logic [3:0]  granted_reg;
      logic        granted;
   } pool_rsp_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   register_pool_allocator_fifo_spill dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // pool model state
   logic [15:0]  occ_model  = '0;
   logic [15:0]  used_model = '0;
   logic [15:0]  owner_vals[$];
   logic [3:0]   owner_regs[$];
   pool_rsp_type expected_rsps[$];

   logic [15:0] value_pool[24];
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          mismatches     = 0;
   int          accepted_reqs  = 0;
   int          checked_rsps   = 0;
   int          spill_count    = 0;
   int          error_count    = 0;
   int          stuck_cycles   = 0;
   logic        rsp_hold       = 1'b0;
   event        hold_go;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int owner_by_reg(logic [3:0] r);
      for (int i = 0; i < owner_regs.size(); i++)
         if (owner_regs[i] == r) return i;
      return -1;
   endfunction

   function automatic int owner_by_value(logic [15:0] v);
      for (int i = 0; i < owner_vals.size(); i++)
         if (owner_vals[i] == v) return i;
      return -1;
   endfunction

   function automatic bit release_register(logic [3:0] r, output logic [15:0] victim);
      int idx;
      occ_model[r] = 1'b0;
      idx = owner_by_reg(r);
      victim = '0;
      if (idx < 0) return 1'b0;
      victim = owner_vals[idx];
      owner_vals.delete(idx);
      owner_regs.delete(idx);
      return 1'b1;
   endfunction

   function automatic void claim_register(logic [3:0] r);
      occ_model[r]  = 1'b1;
      used_model[r] = 1'b1;
   endfunction

   function automatic void assign_register(logic [3:0] r, logic hv, logic [15:0] v);
      int idx;
      if (hv) begin
         idx = owner_by_value(v);
         if (idx >= 0) begin
            owner_vals.delete(idx);
            owner_regs.delete(idx);
         end
         if (owner_vals.size() >= POOL_SIZE) begin
            owner_vals.delete(0);
            owner_regs.delete(0);
         end
         owner_vals = {owner_vals, v};
         owner_regs = {owner_regs, r};
      end
      claim_register(r);
   endfunction

   function automatic pool_rsp_type predict_response(pool_req_type rq);
      pool_rsp_type rs;
      int           pick;
      int           idx;
      logic         hit;
      logic         busy;
      logic [15:0]  victim;
      rs = '0;
      hit = 1'b0;
      victim = '0;
      case (rq.opcode)
         OP_ALLOC_ANY: begin
            pick = -1;
            for (int k = 0; k < POOL_SIZE; k++)
               if (pick < 0 && !occ_model[k]) pick = k;
            if (pick < 0) begin
               if (owner_regs.size() == 0) begin
                  rs.error = 1'b1;
               end else begin
                  pick = int'(owner_regs[0]);
                  hit = release_register(pick[3:0], victim);
               end
            end
            if (pick >= 0) begin
               assign_register(pick[3:0], rq.has_value, rq.value_id);
               rs.granted     = 1'b1;
               rs.granted_reg = pick[3:0];
            end
         end
         OP_ALLOC_NAMED: begin
            idx = owner_by_value(rq.value_id);
            if (rq.has_value && idx >= 0 && owner_regs[idx] == rq.reg_no) begin
               rs.granted     = 1'b1;
               rs.granted_reg = rq.reg_no;
            end else begin
               busy = occ_model[rq.reg_no];
               if (busy) hit = release_register(rq.reg_no, victim);
               if (busy && !hit) begin
                  rs.error = 1'b1;
               end else begin
                  assign_register(rq.reg_no, rq.has_value, rq.value_id);
                  rs.granted     = 1'b1;
                  rs.granted_reg = rq.reg_no;
               end
            end
         end
         OP_RESERVE: begin
            if (occ_model[rq.reg_no]) hit = release_register(rq.reg_no, victim);
            claim_register(rq.reg_no);
            rs.granted     = 1'b1;
            rs.granted_reg = rq.reg_no;
         end
         OP_FREE_REG: begin
            hit = release_register(rq.reg_no, victim);
         end
         OP_FREE_VALUE: begin
            idx = owner_by_value(rq.value_id);
            if (idx >= 0) hit = release_register(owner_regs[idx], victim);
         end
         default: begin
         end
      endcase
      rs.spilled          = hit;
      rs.spilled_value_id = hit ? victim : 16'h0000;
      rs.occupied_mask    = occ_model;
      rs.used_mask        = used_model;
      return rs;
   endfunction

   // check each response, then record the prediction for each new request
   always @(posedge clock) begin : monitor
      pool_rsp_type got;
      pool_rsp_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response %h with nothing pending", rsp_tdata);
            end else begin
               want = expected_rsps.pop_front();
               checked_rsps++;
               if (got.spilled === 1'b1) spill_count++;
               if (got.error === 1'b1) error_count++;
               if (got.granted !== want.granted || got.granted_reg !== want.granted_reg ||
                   got.spilled !== want.spilled ||
                   got.spilled_value_id !== want.spilled_value_id ||
                   got.error !== want.error || got.occupied_mask !== want.occupied_mask ||
                   got.used_mask !== want.used_mask || got.zero_pad !== want.zero_pad) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("response %0d mismatch at %0t", checked_rsps, $realtime);
                     $display({"  expected: grant=%0d reg=%0d spill=%0d id=%h err=%0d",
                               " occ=%h used=%h pad=%0d"},
                              want.granted, want.granted_reg, want.spilled,
                              want.spilled_value_id, want.error, want.occupied_mask,
                              want.used_mask, want.zero_pad);
                     $display({"  actual:   grant=%0d reg=%0d spill=%0d id=%h err=%0d",
                               " occ=%h used=%h pad=%0d"},
                              got.granted, got.granted_reg, got.spilled,
                              got.spilled_value_id, got.error, got.occupied_mask,
                              got.used_mask, got.zero_pad);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            accepted_reqs++;
            expected_rsps = {expected_rsps, predict_response(req_tdata)};
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_hold)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // hold off the response side for a long stretch
   always begin
      @(hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   function automatic pool_req_type req_item(op_type op, logic hv, logic [15:0] v,
                                             logic [3:0] r);
      pool_req_type rq;
      rq.opcode    = op;
      rq.has_value = hv;
      rq.value_id  = v;
      rq.reg_no    = r;
      return rq;
   endfunction

   function automatic pool_req_type random_request(bit filling);
      pool_req_type rq;
      int           p;
      int           pick;
      p = $urandom_range(0, 99);
      rq.reg_no    = 4'($urandom_range(0, 15));
      rq.has_value = ($urandom_range(0, 9) < 8);
      rq.value_id  = ($urandom_range(0, 9) < 7) ? value_pool[$urandom_range(0, 23)]
                                                : 16'($urandom_range(0, 16'hFFFF));
      if (filling)
         rq.opcode = p < 40 ? OP_ALLOC_ANY : p < 65 ? OP_ALLOC_NAMED :
                     p < 75 ? OP_RESERVE : p < 87 ? OP_FREE_REG : OP_FREE_VALUE;
      else
         rq.opcode = p < 15 ? OP_ALLOC_ANY : p < 25 ? OP_ALLOC_NAMED :
                     p < 30 ? OP_RESERVE : p < 65 ? OP_FREE_REG : OP_FREE_VALUE;
      // aim at a current owner to hit the already-held and free-by-value paths
      if ((rq.opcode == OP_ALLOC_NAMED || rq.opcode == OP_FREE_VALUE) &&
          owner_vals.size() > 0 && $urandom_range(0, 1) == 1) begin
         pick = $urandom_range(0, owner_vals.size() - 1);
         rq.value_id = owner_vals[pick];
         rq.reg_no   = owner_regs[pick];
      end
      return rq;
   endfunction

   task automatic send_request(input pool_req_type rq);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rq;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_basic_ops();
      send_request(req_item(OP_ALLOC_ANY,   1'b1, 16'h0000, 4'd0));
      send_request(req_item(OP_ALLOC_NAMED, 1'b1, 16'h0000, 4'd0));
      send_request(req_item(OP_ALLOC_NAMED, 1'b1, 16'hFFFF, 4'd15));
      // same value moves to another register: old one stays occupied, no owner
      send_request(req_item(OP_ALLOC_NAMED, 1'b1, 16'hFFFF, 4'd7));
      send_request(req_item(OP_ALLOC_NAMED, 1'b0, 16'h1234, 4'd15));
      send_request(req_item(OP_RESERVE,     1'b0, 16'h0000, 4'd7));
      send_request(req_item(OP_FREE_VALUE,  1'b1, 16'h1234, 4'd0));
      send_request(req_item(OP_FREE_VALUE,  1'b1, 16'h0000, 4'd0));
      send_request(req_item(OP_FREE_REG,    1'b0, 16'h0000, 4'd3));
   endtask

   task automatic test_full_pool();
      for (int r = 0; r < POOL_SIZE; r++)
         if (r != 7) send_request(req_item(OP_RESERVE, 1'b0, 16'h0000, r[3:0]));
      send_request(req_item(OP_ALLOC_ANY,   1'b0, 16'h5A5A, 4'd0));
      send_request(req_item(OP_ALLOC_NAMED, 1'b1, 16'h5A5A, 4'd3));
      send_request(req_item(OP_ALLOC_ANY,   1'b1, 16'h5A5A, 4'd0));
      send_request(req_item(OP_ALLOC_ANY,   1'b1, 16'hA5A5, 4'd0));
      send_request(req_item(OP_FREE_REG,    1'b0, 16'h0000, 4'd3));
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (int i = 0; i < count; i++)
         send_request(random_request(((i / 48) % 2) == 0));
   endtask

   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      -> hold_go;
      for (int i = 0; i < 40; i++)
         send_request(random_request(1'b1));
   endtask

   initial begin
      for (int i = 0; i < 24; i++)
         value_pool[i] = 16'($urandom_range(0, 16'hFFFF));
      value_pool[0] = 16'h0000;
      value_pool[1] = 16'hFFFF;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_full_pool();
      test_random_traffic(0, 0, RANDOM_ITEMS);
      test_random_traffic(47, 0, RANDOM_ITEMS);
      test_random_traffic(0, 47, RANDOM_ITEMS);
      test_random_traffic(21, 21, RANDOM_ITEMS);
      test_backpressure();
      wait_drained();

      $display({"Ran %0d requests: directed pool cases, random mixes under idle/stall,",
                " long hold-off."}, accepted_reqs);
      $display("Checked %0d responses (%0d spills, %0d eviction errors), %0d mismatches.",
               checked_rsps, spill_count, error_count, mismatches);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/rpa_pkg.sv
hw/rtl/rpa_cell.sv
hw/rtl/rpa_find_free.sv
hw/rtl/register_pool_allocator_fifo_spill.sv
sim/register_pool_allocator_fifo_spill_tb.sv
